FILE: rtl/vfcm_pkg.sv
// ----------------------------------------------------------------------------
// vfcm_pkg: shared definitions for the voxel face-cull mesher
// Store geometry, field widths, input and face codes, and the sequencer's
// control-word ROM with the corner-offset table.
// ----------------------------------------------------------------------------
`default_nettype none

package vfcm_pkg;

  // Store geometry
  localparam int SIDE_X     = 16;
  localparam int SIDE_Y     = 16;
  localparam int SIDE_Z     = 16;
  localparam int KIND_COUNT = 16;
  localparam int CELLS      = SIDE_X * SIDE_Y * SIDE_Z;
  localparam int ADDR_W     = $clog2(CELLS);

  // Field widths
  localparam int MODE_W     = 2;
  localparam int COORD_W    = 4;
  localparam int KIND_W     = 4;
  localparam int CORNER_W   = 5;
  localparam int LAYER_W    = 4;
  localparam int FACE_W     = 3;
  localparam int CNT_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int MASK_W     = 16;
  localparam int FACE_COUNT = 6;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EVAL    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LAYER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LAYER   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOT_LAYER   = 2'd3;

  // Face codes
  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

  // Micro-ops
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_END        = 3'd0;
  localparam logic [OP_W-1:0] OP_RD_CENTER  = 3'd1;
  localparam logic [OP_W-1:0] OP_CHK_CENTER = 3'd2;
  localparam logic [OP_W-1:0] OP_CHK_NB     = 3'd3;
  localparam logic [OP_W-1:0] OP_SEEK       = 3'd4;
  localparam logic [OP_W-1:0] OP_EMIT       = 3'd5;

  // Program layout
  localparam int PC_W        = 6;
  localparam int PC_CHK_CTR  = 1;
  localparam int PC_CHK_NB0  = 2;
  localparam int PC_SEEK     = PC_CHK_NB0 + FACE_COUNT;
  localparam int PC_EMIT0    = PC_SEEK + 1;
  localparam int PC_LAST     = PC_EMIT0 + 4 * FACE_COUNT - 1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [FACE_W-1:0] face;
    logic [1:0]        corner;
    logic              rd_en;
    logic              rd_center;
    logic [FACE_W-1:0] rd_face;
  } ucode_t;

  // Control ROM: one word per program step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    int     p;
    w  = '0;
    p  = int'(pc);
    w.op = OP_END;
    if (p == 0) begin
      w.op        = OP_RD_CENTER;
      w.rd_en     = 1'b1;
      w.rd_center = 1'b1;
    end else if (p == PC_CHK_CTR) begin
      w.op      = OP_CHK_CENTER;
      w.rd_en   = 1'b1;
      w.rd_face = FACE_PX;
    end else if (p >= PC_CHK_NB0 && p < PC_SEEK) begin
      w.op      = OP_CHK_NB;
      w.face    = FACE_W'(p - PC_CHK_NB0);
      w.rd_en   = ((p - PC_CHK_NB0) < (FACE_COUNT - 1));
      w.rd_face = FACE_W'(p - PC_CHK_NB0 + 1);
    end else if (p == PC_SEEK) begin
      w.op = OP_SEEK;
    end else if (p >= PC_EMIT0 && p <= PC_LAST) begin
      w.op     = OP_EMIT;
      w.face   = FACE_W'((p - PC_EMIT0) / 4);
      w.corner = 2'((p - PC_EMIT0) % 4);
    end
    return w;
  endfunction

  // Corner offset {dx, dy, dz} per face and corner
  function automatic logic [2:0] corner_off(input logic [FACE_W-1:0] face,
                                            input logic [1:0] corner);
    logic [2:0] r;
    case ({face, corner})
      {FACE_PX, 2'd0}: r = 3'b101;
      {FACE_PX, 2'd1}: r = 3'b100;
      {FACE_PX, 2'd2}: r = 3'b110;
      {FACE_PX, 2'd3}: r = 3'b111;
      {FACE_NX, 2'd0}: r = 3'b000;
      {FACE_NX, 2'd1}: r = 3'b001;
      {FACE_NX, 2'd2}: r = 3'b011;
      {FACE_NX, 2'd3}: r = 3'b010;
      {FACE_PY, 2'd0}: r = 3'b011;
      {FACE_PY, 2'd1}: r = 3'b111;
      {FACE_PY, 2'd2}: r = 3'b110;
      {FACE_PY, 2'd3}: r = 3'b010;
      {FACE_NY, 2'd0}: r = 3'b000;
      {FACE_NY, 2'd1}: r = 3'b100;
      {FACE_NY, 2'd2}: r = 3'b101;
      {FACE_NY, 2'd3}: r = 3'b001;
      {FACE_PZ, 2'd0}: r = 3'b001;
      {FACE_PZ, 2'd1}: r = 3'b101;
      {FACE_PZ, 2'd2}: r = 3'b111;
      {FACE_PZ, 2'd3}: r = 3'b011;
      {FACE_NZ, 2'd0}: r = 3'b100;
      {FACE_NZ, 2'd1}: r = 3'b000;
      {FACE_NZ, 2'd2}: r = 3'b010;
      {FACE_NZ, 2'd3}: r = 3'b110;
      default:         r = 3'b000;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [COORD_W-1:0] z);
    return ADDR_W'((int'(x) * SIDE_Y + int'(y)) * SIDE_Z + int'(z));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/voxel_face_cull_mesher.sv
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher: face-culling mesher over a cubic voxel store
// Holds a 16x16x16 store of 4-bit block types and emits four vertex items,
// one per cycle unless stalled, for each visible face of an evaluated cell.
// ----------------------------------------------------------------------------
// Usage: after reset the block clears its voxel store to air, one cell per
// cycle, through all 4096 cells; in_stall stays high during that pass while
// configuration writes are taken as usual. Write-cell and restart-mesh items
// do not start the sequencer. An evaluate item runs a short microprogram: it
// reads the cell, tests it (an air cell ends here), tests the six neighbors,
// picks the first visible face, then emits four vertices per visible face.
// The single read port of the voxel memory takes the seven reads (the cell
// and its six neighbors) one at a time, and the one output register sets the
// vertex rate. A new item is taken once the program has ended, even while the
// final vertex still waits in the output register. Faces come out in the
// order +X, -X, +Y, -Y, +Z, -Z; a neighbor outside the store counts as
// transparent; last marks the final vertex of the cell.
`default_nettype none

module voxel_face_cull_mesher
  import vfcm_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,

  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,

  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire [MODE_W-1:0]      in_mode,
  input  wire [COORD_W-1:0]     in_cell_x,
  input  wire [COORD_W-1:0]     in_cell_y,
  input  wire [COORD_W-1:0]     in_cell_z,
  input  wire [KIND_W-1:0]      in_block_kind,

  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [CORNER_W-1:0]   out_corner_x,
  output logic [CORNER_W-1:0]   out_corner_y,
  output logic [CORNER_W-1:0]   out_corner_z,
  output logic                  out_tex_u,
  output logic                  out_tex_v,
  output logic [LAYER_W-1:0]    out_tex_layer,
  output logic [FACE_W-1:0]     out_face_code,
  output logic [CNT_W-1:0]      out_vertex_number,
  output logic                  out_last
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MASK_W-1:0]     tmask_r;
  logic [CFG_DATA_W-1:0] side_tbl_r;
  logic [CFG_DATA_W-1:0] top_tbl_r;
  logic [CFG_DATA_W-1:0] bot_tbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmask_r    <= MASK_W'(1);
      side_tbl_r <= '0;
      top_tbl_r  <= '0;
      bot_tbl_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRANSPARENT: tmask_r    <= cfg_wdata[MASK_W-1:0];
        CFG_SIDE_LAYER:  side_tbl_r <= cfg_wdata;
        CFG_TOP_LAYER:   top_tbl_r  <= cfg_wdata;
        CFG_BOT_LAYER:   bot_tbl_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  logic                  running_r, running_nxt;
  logic [PC_W-1:0]       pc_r, pc_nxt;
  logic [COORD_W-1:0]    x_r, x_nxt;
  logic [COORD_W-1:0]    y_r, y_nxt;
  logic [COORD_W-1:0]    z_r, z_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [FACE_COUNT-1:0] vis_r, vis_nxt;
  logic                  nb_out_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  // Clearing pass
  logic                  clr_busy_r;
  logic [ADDR_W-1:0]     clr_addr_r;

  // Voxel memory
  logic [KIND_W-1:0]     mem [CELLS];
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [KIND_W-1:0]     mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [KIND_W-1:0]     rd_data_r;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [CORNER_W-1:0]   o_cx_r, o_cy_r, o_cz_r;
  logic                  o_u_r, o_v_r;
  logic [LAYER_W-1:0]    o_layer_r;
  logic [FACE_W-1:0]     o_face_r;
  logic [CNT_W-1:0]      o_vnum_r;
  logic                  o_last_r;

  ucode_t                ctl;
  logic                  in_fire;
  logic                  in_inside;
  logic                  write_fire;
  logic                  emit_fire;
  logic                  out_free;

  assign ctl      = ucode_rom(pc_r);
  assign in_stall = clr_busy_r | running_r;
  assign in_fire  = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  assign in_inside = (int'(in_cell_x) < SIDE_X) && (int'(in_cell_y) < SIDE_Y) &&
                     (int'(in_cell_z) < SIDE_Z);
  assign write_fire = in_fire && (in_mode == MODE_WRITE) && in_inside &&
                      (int'(in_block_kind) < KIND_COUNT);
  assign emit_fire  = running_r && (ctl.op == OP_EMIT) && out_free;

  // --------------------------------------------------------------------------
  // Neighbor address for the face being read; flag it when it leaves the store
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] nx, ny, nz;
  logic               nb_outside;

  always_comb begin
    nx = x_r;
    ny = y_r;
    nz = z_r;
    nb_outside = 1'b0;
    case (ctl.rd_face)
      FACE_PX: begin
        nx = x_r + COORD_W'(1);
        nb_outside = (int'(x_r) + 1 >= SIDE_X);
      end
      FACE_NX: begin
        nx = x_r - COORD_W'(1);
        nb_outside = (x_r == '0);
      end
      FACE_PY: begin
        ny = y_r + COORD_W'(1);
        nb_outside = (int'(y_r) + 1 >= SIDE_Y);
      end
      FACE_NY: begin
        ny = y_r - COORD_W'(1);
        nb_outside = (y_r == '0);
      end
      FACE_PZ: begin
        nz = z_r + COORD_W'(1);
        nb_outside = (int'(z_r) + 1 >= SIDE_Z);
      end
      FACE_NZ: begin
        nz = z_r - COORD_W'(1);
        nb_outside = (z_r == '0);
      end
      default: ;
    endcase
  end

  assign mem_re    = running_r & ctl.rd_en;
  assign mem_raddr = ctl.rd_center ? cell_addr(x_r, y_r, z_r) : cell_addr(nx, ny, nz);

  // Write port is shared by the clearing pass and write-cell items
  assign mem_we    = clr_busy_r | write_fire;
  assign mem_waddr = clr_busy_r ? clr_addr_r : cell_addr(in_cell_x, in_cell_y, in_cell_z);
  assign mem_wdata = clr_busy_r ? '0 : in_block_kind;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Seek: lowest visible face above the current one (all faces on OP_SEEK)
  // --------------------------------------------------------------------------
  logic [FACE_COUNT-1:0] seek_cand;
  logic                  seek_found;
  logic [FACE_W-1:0]     seek_face;
  logic [PC_W-1:0]       seek_pc;

  always_comb begin
    for (int i = 0; i < FACE_COUNT; i++) begin
      seek_cand[i] = vis_r[i] && ((ctl.op == OP_SEEK) || (i > int'(ctl.face)));
    end
    seek_found = |seek_cand;
    seek_face  = '0;
    for (int i = FACE_COUNT - 1; i >= 0; i--) begin
      if (seek_cand[i]) begin
        seek_face = FACE_W'(i);
      end
    end
    seek_pc = PC_W'(PC_EMIT0 + 4 * int'(seek_face));
  end

  // --------------------------------------------------------------------------
  // Vertex fields for the current step
  // --------------------------------------------------------------------------
  logic [2:0]            off;
  logic [CFG_DATA_W-1:0] layer_tbl;
  logic [LAYER_W-1:0]    layer;

  assign off = corner_off(ctl.face, ctl.corner);

  always_comb begin
    case (ctl.face)
      FACE_PY: layer_tbl = top_tbl_r;
      FACE_NY: layer_tbl = bot_tbl_r;
      default: layer_tbl = side_tbl_r;
    endcase
  end

  assign layer = layer_tbl[{kind_r, 2'b00} +: LAYER_W];

  // --------------------------------------------------------------------------
  // Sequencer next state
  // --------------------------------------------------------------------------
  always_comb begin
    running_nxt = running_r;
    pc_nxt      = pc_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    z_nxt       = z_r;
    kind_nxt    = kind_r;
    vis_nxt     = vis_r;
    cnt_nxt     = cnt_r;

    if (in_fire) begin
      case (in_mode)
        MODE_RESTART: cnt_nxt = '0;
        MODE_EVAL: begin
          if (in_inside) begin
            running_nxt = 1'b1;
            pc_nxt      = '0;
            x_nxt       = in_cell_x;
            y_nxt       = in_cell_y;
            z_nxt       = in_cell_z;
            vis_nxt     = '0;
          end
        end
        default: ;
      endcase
    end

    if (running_r) begin
      case (ctl.op)
        OP_RD_CENTER: pc_nxt = pc_r + PC_W'(1);
        OP_CHK_CENTER: begin
          // Air emits nothing: drop the item
          if (rd_data_r == '0) begin
            running_nxt = 1'b0;
          end else begin
            kind_nxt = rd_data_r;
            pc_nxt   = pc_r + PC_W'(1);
          end
        end
        OP_CHK_NB: begin
          vis_nxt[ctl.face] = nb_out_r | tmask_r[rd_data_r];
          pc_nxt            = pc_r + PC_W'(1);
        end
        OP_SEEK: begin
          if (seek_found) begin
            pc_nxt = seek_pc;
          end else begin
            running_nxt = 1'b0;
          end
        end
        OP_EMIT: begin
          // Hold the step until the output register frees up
          if (out_free) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            if (ctl.corner == 2'd3) begin
              if (seek_found) begin
                pc_nxt = seek_pc;
              end else begin
                running_nxt = 1'b0;
              end
            end else begin
              pc_nxt = pc_r + PC_W'(1);
            end
          end
        end
        default: running_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 1'b0;
      pc_r       <= '0;
      vis_r      <= '0;
      cnt_r      <= '0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      running_r <= running_nxt;
      pc_r      <= pc_nxt;
      vis_r     <= vis_nxt;
      cnt_r     <= cnt_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    kind_r <= kind_nxt;
    if (mem_re) begin
      nb_out_r <= nb_outside;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      o_cx_r    <= CORNER_W'(x_r) + CORNER_W'(off[2]);
      o_cy_r    <= CORNER_W'(y_r) + CORNER_W'(off[1]);
      o_cz_r    <= CORNER_W'(z_r) + CORNER_W'(off[0]);
      o_u_r     <= ctl.corner[0] ^ ctl.corner[1];
      o_v_r     <= ctl.corner[1];
      o_layer_r <= layer;
      o_face_r  <= ctl.face;
      o_vnum_r  <= cnt_r;
      o_last_r  <= (ctl.corner == 2'd3) && !seek_found;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_corner_x      = o_cx_r;
  assign out_corner_y      = o_cy_r;
  assign out_corner_z      = o_cz_r;
  assign out_tex_u         = o_u_r;
  assign out_tex_v         = o_v_r;
  assign out_tex_layer     = o_layer_r;
  assign out_face_code     = o_face_r;
  assign out_vertex_number = o_vnum_r;
  assign out_last          = o_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (pc_r <= PC_W'(PC_LAST)))
    else $error("sequencer step beyond program end");

  a_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |-> vis_r[ctl.face])
    else $error("vertex emitted for a hidden face");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (cnt_r == CNT_W'($past(cnt_r) + CNT_W'(1))))
    else $error("vertex counter did not advance on emit");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && (ctl.corner == 2'd3) && !seek_found) |=> !running_r)
    else $error("sequencer still running after last vertex");

  a_no_read_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !running_r)
    else $error("evaluation started during clearing pass");

endmodule

`default_nettype wire
